// ----- rtl/i2a_pkg.sv -----
// Package: shared types, mode codes and character constants for the formatter.
`timescale 1ns / 1ps
`default_nettype none
package i2a_pkg;

  localparam int NUM_DIGITS    = 10;
  localparam int NUM_POS       = 11;
  localparam int BITS_PER_STEP = 4;

  localparam logic [3:0] FUNC_U32_DEC = 4'd0;
  localparam logic [3:0] FUNC_S32_DEC = 4'd1;
  localparam logic [3:0] FUNC_U16_DEC = 4'd2;
  localparam logic [3:0] FUNC_S16_DEC = 4'd3;
  localparam logic [3:0] FUNC_U8_DEC  = 4'd4;
  localparam logic [3:0] FUNC_S8_DEC  = 4'd5;
  localparam logic [3:0] FUNC_HEX32   = 4'd6;
  localparam logic [3:0] FUNC_HEX16   = 4'd7;
  localparam logic [3:0] FUNC_HEX8    = 4'd8;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  localparam logic [3:0] NIB_FIVE  = 4'h5;
  localparam logic [3:0] NIB_THREE = 4'h3;
  localparam logic [3:0] NIB_TEN   = 4'hA;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       is_last;
    logic [3:0] text_length;
  } out_t;

  // converter to emitter hand-over
  typedef struct packed {
    logic        hex;
    logic        neg;
    logic [3:0]  ndig;
    logic [39:0] bcd;
    logic [31:0] hexval;
  } conv_t;

endpackage
`default_nettype wire

// ----- rtl/i2a_digit_cell.sv -----
// One BCD digit of the double dabble row: add-3 and shift, four bits per cycle while shift is high.
`timescale 1ns / 1ps
`default_nettype none
module i2a_digit_cell (
  input  wire logic       clk,
  input  wire logic       clear,
  input  wire logic       shift,
  input  wire logic [3:0] cin,
  output logic      [3:0] cout,
  output logic      [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] nib [5];
  logic [3:0] adj [4];

  // cin[3] is the first bit in, cout[3] the first bit out
  always_comb begin
    nib[0] = digit_r;
    for (int j = 0; j < i2a_pkg::BITS_PER_STEP; j++) begin
      adj[j] = (nib[j] >= i2a_pkg::NIB_FIVE) ? nib[j] + i2a_pkg::NIB_THREE : nib[j];
      cout[3-j] = adj[j][3];
      nib[j+1] = {adj[j][2:0], cin[3-j]};
    end
    digit_nxt = nib[4];
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit_r <= '0;
    end else if (shift) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule
`default_nettype wire

// ----- rtl/i2a_converter.sv -----
// Mode decode, sign handling and the row of double dabble digit cells.
`timescale 1ns / 1ps
`default_nettype none
module i2a_converter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire i2a_pkg::in_t  in_data,
  input  wire logic          emit_free,
  output logic               busy,
  output logic               xfer,
  output i2a_pkg::conv_t     res
);

  logic        busy_r;
  logic [3:0]  steps_r;
  logic [31:0] bin_r;
  logic        hex_r;
  logic        neg_r;
  logic [3:0]  ndig_r;

  logic        accept;
  logic        func_ok;
  logic        is_hex;
  logic        is_signed;
  logic [3:0]  ndig;
  logic [31:0] mask;
  logic [31:0] vm;
  logic        msb;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] mag_just;
  logic        shifting;

  logic [3:0]  cin   [i2a_pkg::NUM_DIGITS];
  logic [3:0]  cout  [i2a_pkg::NUM_DIGITS];
  logic [3:0]  digit [i2a_pkg::NUM_DIGITS];

  always_comb begin
    func_ok   = 1'b1;
    is_hex    = 1'b0;
    is_signed = 1'b0;
    ndig      = 4'd8;
    case (in_data.func) inside
      i2a_pkg::FUNC_U32_DEC, i2a_pkg::FUNC_S32_DEC, i2a_pkg::FUNC_HEX32: ndig = 4'd8;
      i2a_pkg::FUNC_U16_DEC, i2a_pkg::FUNC_S16_DEC, i2a_pkg::FUNC_HEX16: ndig = 4'd4;
      i2a_pkg::FUNC_U8_DEC,  i2a_pkg::FUNC_S8_DEC,  i2a_pkg::FUNC_HEX8:  ndig = 4'd2;
      default: func_ok = 1'b0;
    endcase
    if (in_data.func inside {i2a_pkg::FUNC_HEX32, i2a_pkg::FUNC_HEX16, i2a_pkg::FUNC_HEX8}) begin
      is_hex = 1'b1;
    end
    if (in_data.func inside {i2a_pkg::FUNC_S32_DEC, i2a_pkg::FUNC_S16_DEC,
                             i2a_pkg::FUNC_S8_DEC}) begin
      is_signed = 1'b1;
    end
    case (ndig)
      4'd4: begin
        mask = 32'h0000_FFFF;
        msb  = in_data.value[15];
      end
      4'd2: begin
        mask = 32'h0000_00FF;
        msb  = in_data.value[7];
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        msb  = in_data.value[31];
      end
    endcase
    vm  = in_data.value & mask;
    neg = is_signed && msb;
    mag = neg ? ((~vm) + 32'd1) & mask : vm;
    case (ndig)
      4'd4:    mag_just = {mag[15:0], 16'b0};
      4'd2:    mag_just = {mag[7:0], 24'b0};
      default: mag_just = mag;
    endcase
  end

  assign xfer     = busy_r && (steps_r == 4'd0) && emit_free;
  assign busy     = busy_r && !xfer;
  assign accept   = start && !busy;
  assign shifting = busy_r && (steps_r != 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      steps_r <= 4'd0;
    end else if (accept && func_ok) begin
      busy_r  <= 1'b1;
      steps_r <= is_hex ? 4'd0 : ndig;
    end else if (shifting) begin
      steps_r <= steps_r - 4'd1;
    end else if (xfer) begin
      busy_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func_ok) begin
      bin_r  <= is_hex ? vm : mag_just;
      hex_r  <= is_hex;
      neg_r  <= neg && !is_hex;
      ndig_r <= ndig;
    end else if (shifting) begin
      bin_r  <= {bin_r[27:0], 4'b0};
    end
  end

  assign cin[0] = bin_r[31:28];

  for (genvar d = 0; d < i2a_pkg::NUM_DIGITS; d++) begin : g_cell
    if (d > 0) begin : g_link
      assign cin[d] = cout[d-1];
    end
    i2a_digit_cell u_cell (
      .clk   (clk),
      .clear (accept && func_ok),
      .shift (shifting),
      .cin   (cin[d]),
      .cout  (cout[d]),
      .digit (digit[d])
    );
  end

  always_comb begin
    res.hex    = hex_r;
    res.neg    = neg_r;
    res.ndig   = ndig_r;
    res.hexval = bin_r;
    for (int d = 0; d < i2a_pkg::NUM_DIGITS; d++) begin
      res.bcd[4*d +: 4] = digit[d];
    end
  end

  a_idle_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> steps_r == 4'd0)
    else $error("steps pending while converter idle");

  a_steps_count: assert property (@(posedge clk) disable iff (!rst_n)
    shifting |=> steps_r == $past(steps_r) - 4'd1)
    else $error("dabble step count skipped");

  a_no_early_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> !shifting || $past(accept))
    else $error("conversion still running after transfer");

endmodule
`default_nettype wire

// ----- rtl/i2a_emitter.sv -----
// Character shift line: builds the eleven character slots and shifts one out per cycle.
`timescale 1ns / 1ps
`default_nettype none
module i2a_emitter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire i2a_pkg::conv_t res,
  output logic                emit_free,
  output logic                out_valid,
  output i2a_pkg::out_t       out_data
);

  localparam int NP = i2a_pkg::NUM_POS;

  i2a_pkg::out_t cell_r [NP];
  logic [NP-1:0] vld_r;
  logic [3:0]    cnt_r;

  i2a_pkg::out_t cell_nxt [NP];
  logic [NP-1:0] vld_nxt;
  logic [i2a_pkg::NUM_DIGITS-1:0] started;
  logic [39:0]   hex_wide;
  logic [3:0]    len;
  logic [3:0]    nib;

  always_comb begin
    hex_wide = {8'b0, res.hexval};
    started[i2a_pkg::NUM_DIGITS-1] = res.bcd[39:36] != 4'd0;
    for (int d = i2a_pkg::NUM_DIGITS - 2; d >= 0; d--) begin
      started[d] = started[d+1] || (res.bcd[4*d +: 4] != 4'd0) || (d == 0);
    end
    for (int p = 0; p < NP; p++) begin
      cell_nxt[p] = '0;
      vld_nxt[p]  = 1'b0;
    end
    cell_nxt[0].char_code = i2a_pkg::CHAR_MINUS;
    vld_nxt[0] = res.neg;
    for (int p = 1; p < NP; p++) begin
      if (res.hex) begin
        nib = hex_wide[4*(NP-1-p) +: 4];
        cell_nxt[p].char_code = (nib < i2a_pkg::NIB_TEN) ?
                                i2a_pkg::CHAR_ZERO + {3'b0, nib} :
                                i2a_pkg::CHAR_A + {3'b0, nib} - {3'b0, i2a_pkg::NIB_TEN};
        vld_nxt[p] = (p >= 3) && (4'(NP - 1 - p) < res.ndig);
      end else begin
        nib = res.bcd[4*(NP-1-p) +: 4];
        cell_nxt[p].char_code = i2a_pkg::CHAR_ZERO + {3'b0, nib};
        vld_nxt[p] = started[NP-1-p];
      end
    end
    len = 4'd0;
    for (int p = 0; p < NP; p++) begin
      len = len + {3'b0, vld_nxt[p]};
    end
    cell_nxt[NP-1].is_last     = 1'b1;
    cell_nxt[NP-1].text_length = len;
  end

  assign emit_free = cnt_r <= 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= 4'd0;
    end else if (load) begin
      vld_r <= vld_nxt;
      cnt_r <= 4'(NP);
    end else begin
      vld_r <= {1'b0, vld_r[NP-1:1]};
      if (cnt_r != 4'd0) begin
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NP; p++) begin
      if (load) begin
        cell_r[p] <= cell_nxt[p];
      end else if (p < NP - 1) begin
        cell_r[p] <= cell_r[p+1];
      end
    end
  end

  assign out_valid = vld_r[0];
  assign out_data  = cell_r[0];

  a_valid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 4'd0)
    else $error("character strobe outside an active slot window");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_last |-> cnt_r == 4'd1)
    else $error("last character not in final slot");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> emit_free)
    else $error("shift line overwritten while characters pending");

endmodule
`default_nettype wire

// ----- rtl/integer_to_ascii_formatter.sv -----
// Top level: integer to ASCII formatter, decimal by double dabble or fixed-width hex.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input: present in_data (func, value) with start; the number transfers at a rising
//   edge where start is high and busy is low. Unused func codes transfer and give nothing.
//   Output: each character appears on out_data for one cycle with out_valid high; the
//   receiver must take it then. Characters come most significant first, possibly with
//   idle cycles between them where leading zeros were dropped. The final character has
//   is_last set and text_length holding the character count.
//   Flow: the digit row converts four bits per cycle for decimal modes and is skipped for hex;
//   the result is then handed to the eleven-slot character line once that line is free, and
//   the line then shifts the characters out.
//   Overlap: the eleven-slot character line, which shifts one slot per cycle, sets the pace;
//   the next number converts while the current one is shifted out, and busy drops in the
//   cycle of hand-over.
//   Reset (synchronous, rst_n low) empties both stages; no characters are pending after.
module integer_to_ascii_formatter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire i2a_pkg::in_t  in_data,
  output logic               out_valid,
  output i2a_pkg::out_t      out_data
);

  logic           emit_free;
  logic           xfer;
  i2a_pkg::conv_t res;

  i2a_converter u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .emit_free (emit_free),
    .busy      (busy),
    .xfer      (xfer),
    .res       (res)
  );

  i2a_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (xfer),
    .res       (res),
    .emit_free (emit_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
